@@ rtl/lcgbr_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lcgbr_pkg
// Shared types and constants for the bounded LCG random number block.
// ============================================================================
package lcgbr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 5;     // log2 of DATA_W

    localparam logic [DATA_W-1:0] LCG_MUL    = 32'd3877;
    localparam logic [DATA_W-1:0] LCG_INC    = 32'd29573;
    localparam logic [DATA_W-1:0] SEED_RESET = 32'd42;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [DATA_W-1:0] operand_value;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] random_value;
        logic [DATA_W-1:0] current_seed;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic take;      // request accepted this cycle
        logic step;      // advance seed, arm the divider
        logic div;       // one remainder iteration
        logic publish;   // load the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_load;
        logic bound_zero;
        logic div_last;
    } sts_t;

endpackage

@@ rtl/lcgbr_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lcgbr_ctrl
// Sequencer: accept, seed step and 32 divides (nonzero draws only), hand-off.
// ============================================================================
module lcgbr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output lcgbr_pkg::cmd_t  cmd,
    input  lcgbr_pkg::sts_t  sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next  = state_reg;
        cmd.take    = 1'b0;
        cmd.step    = 1'b0;
        cmd.div     = 1'b0;
        cmd.publish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take = 1'b1;
                    if (sts.is_load || sts.bound_zero)
                        state_next = S_DONE;
                    else
                        state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (sts.div_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.publish)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

@@ rtl/lcgbr_dpath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lcgbr_dpath
// Seed register, LCG update and radix-2 restoring remainder unit.
// ============================================================================
module lcgbr_dpath
(
    input  logic             clk,
    input  logic             rst_n,
    input  lcgbr_pkg::req_t  req,
    output lcgbr_pkg::rsp_t  rsp,
    input  lcgbr_pkg::cmd_t  cmd,
    output lcgbr_pkg::sts_t  sts
);

    localparam int unsigned W  = lcgbr_pkg::DATA_W;
    localparam int unsigned CW = lcgbr_pkg::CNT_W;

    logic [W-1:0]  seed_reg;
    logic [W-1:0]  seed_next;
    logic [W-1:0]  bound_reg;
    logic [W-1:0]  dvd_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  value_reg;
    logic [CW-1:0] cnt_reg;
    lcgbr_pkg::rsp_t rsp_reg;

    logic [W-1:0]  lcg_val;
    logic [W:0]    shifted;
    logic [W:0]    trial;
    logic [W-1:0]  rem_new;

    assign sts.is_load    = (req.opcode == lcgbr_pkg::OP_LOAD);
    assign sts.bound_zero = (req.operand_value == '0);
    assign sts.div_last   = (cnt_reg == {CW{1'b1}});

    assign lcg_val = seed_reg * lcgbr_pkg::LCG_MUL + lcgbr_pkg::LCG_INC;

    // restoring step: shift in next dividend bit, subtract if it fits
    assign shifted = {rem_reg, dvd_reg[W-1]};
    assign trial   = shifted - {1'b0, bound_reg};
    assign rem_new = trial[W] ? shifted[W-1:0] : trial[W-1:0];

    always_comb
    begin
        seed_next = seed_reg;
        if (cmd.take && sts.is_load)
            seed_next = req.operand_value;
        else if (cmd.step)
            seed_next = lcg_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= lcgbr_pkg::SEED_RESET;
        else
            seed_reg <= seed_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            bound_reg <= req.operand_value;
            value_reg <= '0;
        end
        if (cmd.step)
        begin
            dvd_reg <= lcg_val;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div)
        begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            rem_reg <= rem_new;
            cnt_reg <= cnt_reg + 1'b1;
            if (sts.div_last)
                value_reg <= rem_new;
        end
        if (cmd.publish)
        begin
            rsp_reg.random_value <= value_reg;
            rsp_reg.current_seed <= seed_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

@@ rtl/lcg_bounded_random.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lcg_bounded_random
// 32-bit LCG with draws below a bound and seed load.
// ============================================================================
// One request at a time. A draw with a nonzero bound advances the seed to
// seed*3877+29573 (mod 2^32) and returns the new seed modulo the bound; a
// draw with bound zero returns 0 and keeps the seed; a load (opcode 1)
// replaces the seed and returns 0. Every response also carries the seed as
// it stands after the request. Seed resets to 42. A nonzero draw reaches the
// response register after a seed-update step, the bit-serial restoring
// remainder unit's iterations at one bit per cycle, and a hand-off that
// waits while the output register still holds an untaken response; loads
// and zero-bound draws go straight to the hand-off. The next request is
// taken the cycle after the hand-off, so requests never overlap.
// req_stall is high while a request is in work; the output register holds a
// finished response so the next request can be accepted while it waits to
// be taken.
module lcg_bounded_random
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  lcgbr_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output lcgbr_pkg::rsp_t  rsp
);

    lcgbr_pkg::cmd_t cmd;
    lcgbr_pkg::sts_t sts;

    lcgbr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    lcgbr_dpath u_dpath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for lcg_bounded_random: draws, zero bounds, seed loads.
// ============================================================================
// A queue of pending requests feeds a clocked driver that sends them in
// random bursts. Each accepted request runs through a local LCG model. The
// model pushes the response it predicts, and a clocked monitor compares
// every response it takes against the oldest prediction. The receiver
// stalls on its own pattern. Twice it holds off for a long stretch, so the
// block fills up and stalls its input.
// ============================================================================
module testbench;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned TAIL_CYCLES = 64;      // > one full draw latency
    localparam int unsigned RAND_REQS   = 1150;

    typedef struct {
        lcgbr_pkg::req_t r;
        bit              drain;    // hold this request until every response has come
    } pending_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_stall;
    lcgbr_pkg::req_t req       = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    lcgbr_pkg::rsp_t rsp;

    pending_t                     pending_reqs[$];
    lcgbr_pkg::rsp_t              expected_rsps[$];
    logic [lcgbr_pkg::DATA_W-1:0] seed_model = lcgbr_pkg::SEED_RESET;
    int unsigned                  err_cnt    = 0;
    int unsigned                  cycle_cnt  = 0;

    // sender burst shaping
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    // receiver stall pattern
    int unsigned rx_cnt    = 0;
    int unsigned hold_left = 0;
    int unsigned rx_mode   = 0;

    lcg_bounded_random dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Advance the seed model by one request and return its response.
    function automatic lcgbr_pkg::rsp_t lcg_step(lcgbr_pkg::req_t rq);
        lcgbr_pkg::rsp_t res;
        res.random_value = '0;
        if (rq.opcode == lcgbr_pkg::OP_LOAD)
        begin
            seed_model = rq.operand_value;
        end
        else if (rq.operand_value != '0)
        begin
            seed_model       = seed_model * lcgbr_pkg::LCG_MUL + lcgbr_pkg::LCG_INC;
            res.random_value = seed_model % rq.operand_value;
        end
        res.current_seed = seed_model;
        return res;
    endfunction

    task automatic add_req(logic op, logic [lcgbr_pkg::DATA_W-1:0] val, bit drain);
        pending_t p;
        p.r.opcode        = op;
        p.r.operand_value = val;
        p.drain           = drain;
        pending_reqs.push_back(p);
    endtask

    // ------------------------------------------------------------------
    // Driver: predicts on acceptance, then presents the next request
    // unless a gap is running or a drain pause is pending.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            seed_model = lcgbr_pkg::SEED_RESET;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(lcg_step(req));
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left  <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                begin
                    req_valid <= 1'b0;
                end
                else if (pending_reqs[0].drain && expected_rsps.size() != 0)
                begin
                    req_valid <= 1'b0;
                end
                else
                begin
                    req       <= pending_reqs[0].r;
                    req_valid <= 1'b1;
                    pending_reqs.pop_front();
                    if (burst_left <= 1)
                    begin
                        // a quarter of bursts run straight into the next one
                        if ($urandom_range(0, 7) == 0)
                            burst_left <= 40;
                        else
                            burst_left <= $urandom_range(1, 8);
                        if ($urandom_range(0, 3) == 0)
                            gap_left <= 0;
                        else
                            gap_left <= $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: rx_cnt decides when a new random mode is drawn.
    // Two long hold-offs back the block up while requests keep coming.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rx_cnt <= rx_cnt + 1;
            if (rx_cnt % 1000 == 0)
                rx_mode <= $urandom_range(0, 3);
            if (rx_cnt == 3000 || rx_cnt == 30000)
            begin
                hold_left <= 400;
                rsp_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (rx_mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 99) < 40);
                    2:       rsp_stall <= (rx_cnt[2:0] < 3);
                    default: rsp_stall <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each response taken against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lcgbr_pkg::rsp_t exp_rsp;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response: random_value %h current_seed %h",
                       rsp.random_value, rsp.current_seed);
                err_cnt++;
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                if (rsp.random_value !== exp_rsp.random_value)
                begin
                    $error("random_value: expected %h, got %h",
                           exp_rsp.random_value, rsp.random_value);
                    err_cnt++;
                end
                if (rsp.current_seed !== exp_rsp.current_seed)
                begin
                    $error("current_seed: expected %h, got %h",
                           exp_rsp.current_seed, rsp.current_seed);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [lcgbr_pkg::DATA_W-1:0] val;
        logic                         op;

        // directed: zero bound on the reset seed, bound extremes, loads
        add_req(lcgbr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);   // seed stays at reset value
        add_req(lcgbr_pkg::OP_DRAW, 32'h0000_0001, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'h0000_0002, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'hFFFF_FFFF, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'h8000_0000, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'h0000_0007, 1'b0);
        add_req(lcgbr_pkg::OP_LOAD, 32'h0000_0000, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'h0000_000A, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        add_req(lcgbr_pkg::OP_LOAD, 32'hFFFF_FFFF, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'hFFFF_FFFF, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'hFFFF_FFFE, 1'b0);
        add_req(lcgbr_pkg::OP_LOAD, 32'hAAAA_AAAA, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'h5555_5555, 1'b0);
        add_req(lcgbr_pkg::OP_LOAD, 32'h5555_5555, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'hAAAA_AAAA, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'h0000_0003, 1'b0);
        add_req(lcgbr_pkg::OP_LOAD, 32'h0000_0000, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);   // zero bound right after load
        add_req(lcgbr_pkg::OP_LOAD, 32'h0000_002A, 1'b0);
        add_req(lcgbr_pkg::OP_DRAW, 32'h0000_0001, 1'b0);

        for (int i = 0; i < RAND_REQS; i++)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                op = lcgbr_pkg::OP_LOAD;
                case ($urandom_range(0, 9))
                    0:       val = '0;
                    1:       val = '1;
                    default: val = $urandom();
                endcase
            end
            else
            begin
                op = lcgbr_pkg::OP_DRAW;
                case ($urandom_range(0, 9))
                    0:       val = '0;
                    1, 2:    val = $urandom_range(1, 16);
                    3:       val = 32'h1 << $urandom_range(0, 31);
                    4:       val = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    5, 6:    val = $urandom_range(1, 65535);
                    default: val = $urandom();
                endcase
            end
            // pause the sender until all responses are in, now and then
            add_req(op, val, (i % 250 == 0));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_rsps.size() != 0)
        begin
            $error("%0d responses never arrived", expected_rsps.size());
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lcgbr_pkg.sv
rtl/lcgbr_ctrl.sv
rtl/lcgbr_dpath.sv
rtl/lcg_bounded_random.sv
tb/testbench.sv
